FILE: hdl/assert_macros.svh
// Assertion macros shared by the escape-time unit modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define MBE_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MBE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mbe_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and saturation helper for the escape-time unit.
// No dependencies; used by mbe_map, mbe_cell and the top level.
package mbe_pkg;

    localparam int WORD_BITS    = 32;
    localparam int WIDE_BITS    = 2 * WORD_BITS;
    localparam int SPACING_BITS = 31;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WIDE_BITS-1:0] SAT_HI   = WIDE_BITS'(WORD_MAX);
    localparam logic signed [WIDE_BITS-1:0] SAT_LO   = WIDE_BITS'(WORD_MIN);

    typedef struct packed {
        logic valid;
        logic done;
    } t_cell_ctrl;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [WIDE_BITS-1:0] value
    );
        logic signed [WORD_BITS-1:0] result;
        if (value > SAT_HI) begin
            result = WORD_MAX;
        end else if (value < SAT_LO) begin
            result = WORD_MIN;
        end else begin
            result = value[WORD_BITS-1:0];
        end
        return result;
    endfunction

endpackage

FILE: hdl/mbe_map.sv
`timescale 1ns / 1ps
// Pixel to complex point mapping: (index - offset) * spacing - centre, saturated.
// Depends on mbe_pkg.
module mbe_map #(
    parameter int COORD_BITS = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_load,
    input  logic [COORD_BITS-1:0]                   i_pixel_col,
    input  logic [COORD_BITS-1:0]                   i_pixel_row,
    input  logic [COORD_BITS-1:0]                   i_origin_offset,
    input  logic [mbe_pkg::SPACING_BITS-1:0]        i_pixel_spacing,
    input  logic signed [mbe_pkg::WORD_BITS-1:0]    i_centre_real,
    input  logic signed [mbe_pkg::WORD_BITS-1:0]    i_centre_imag,
    output logic signed [mbe_pkg::WORD_BITS-1:0]    o_point_re,
    output logic signed [mbe_pkg::WORD_BITS-1:0]    o_point_im
);
    import mbe_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + SPACING_BITS + 1;

    logic signed [DIFF_BITS-1:0]      w_diff_re;
    logic signed [DIFF_BITS-1:0]      w_diff_im;
    logic signed [SPACING_BITS:0]     w_spacing;
    logic signed [PROD_BITS-1:0]      w_prod_re;
    logic signed [PROD_BITS-1:0]      w_prod_im;
    logic signed [WIDE_BITS-1:0]      w_full_re;
    logic signed [WIDE_BITS-1:0]      w_full_im;
    logic signed [WORD_BITS-1:0]      r_point_re;
    logic signed [WORD_BITS-1:0]      r_point_im;

    assign w_diff_re = $signed({1'b0, i_pixel_col}) - $signed({1'b0, i_origin_offset});
    assign w_diff_im = $signed({1'b0, i_pixel_row}) - $signed({1'b0, i_origin_offset});
    assign w_spacing = $signed({1'b0, i_pixel_spacing});
    assign w_prod_re = w_diff_re * w_spacing;
    assign w_prod_im = w_diff_im * w_spacing;
    assign w_full_re = WIDE_BITS'(w_prod_re) - WIDE_BITS'(i_centre_real);
    assign w_full_im = WIDE_BITS'(w_prod_im) - WIDE_BITS'(i_centre_imag);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_point_re <= sat_word(w_full_re);
            r_point_im <= sat_word(w_full_im);
        end
    end

    assign o_point_re = r_point_re;
    assign o_point_im = r_point_im;

endmodule

FILE: hdl/mbe_cell.sv
`timescale 1ns / 1ps
// One cell of the iteration ring: escape test and one z = z*z + c step per cycle.
// Depends on mbe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbe_cell #(
    parameter int FRAC_BITS  = 24,
    parameter int COUNT_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  mbe_pkg::t_cell_ctrl                     i_ctrl,
    input  logic signed [mbe_pkg::WORD_BITS-1:0]    i_z_re,
    input  logic signed [mbe_pkg::WORD_BITS-1:0]    i_z_im,
    input  logic [COUNT_BITS-1:0]                   i_count,
    input  logic signed [mbe_pkg::WORD_BITS-1:0]    i_point_re,
    input  logic signed [mbe_pkg::WORD_BITS-1:0]    i_point_im,
    input  logic [COUNT_BITS-1:0]                   i_limit,
    output mbe_pkg::t_cell_ctrl                     o_ctrl,
    output logic signed [mbe_pkg::WORD_BITS-1:0]    o_z_re,
    output logic signed [mbe_pkg::WORD_BITS-1:0]    o_z_im,
    output logic [COUNT_BITS-1:0]                   o_count
);
    import mbe_pkg::*;

    localparam logic [WIDE_BITS-1:0] ESCAPE = WIDE_BITS'(1) << (2 * FRAC_BITS + 2);

    logic signed [WIDE_BITS-1:0] w_aa;
    logic signed [WIDE_BITS-1:0] w_bb;
    logic signed [WIDE_BITS-1:0] w_ab;
    logic [WIDE_BITS-1:0]        w_mag;
    logic signed [WIDE_BITS-1:0] w_re_full;
    logic signed [WIDE_BITS-1:0] w_im_full;
    logic                        w_stop;

    t_cell_ctrl                  r_ctrl;
    t_cell_ctrl                  n_ctrl;
    logic signed [WORD_BITS-1:0] r_z_re;
    logic signed [WORD_BITS-1:0] n_z_re;
    logic signed [WORD_BITS-1:0] r_z_im;
    logic signed [WORD_BITS-1:0] n_z_im;
    logic [COUNT_BITS-1:0]       r_count;
    logic [COUNT_BITS-1:0]       n_count;

    assign w_aa      = i_z_re * i_z_re;
    assign w_bb      = i_z_im * i_z_im;
    assign w_ab      = i_z_re * i_z_im;
    assign w_mag     = $unsigned(w_aa) + $unsigned(w_bb);
    assign w_stop    = (i_count >= i_limit) || (w_mag >= ESCAPE);
    assign w_re_full = ((w_aa - w_bb) >>> FRAC_BITS) + WIDE_BITS'(i_point_re);
    assign w_im_full = (w_ab >>> (FRAC_BITS - 1)) + WIDE_BITS'(i_point_im);

    always_comb begin
        n_ctrl  = i_ctrl;
        n_z_re  = i_z_re;
        n_z_im  = i_z_im;
        n_count = i_count;
        if (i_ctrl.valid && !i_ctrl.done) begin
            if (w_stop) begin
                n_ctrl.done = 1'b1;
            end else begin
                n_z_re  = sat_word(w_re_full);
                n_z_im  = sat_word(w_im_full);
                n_count = i_count + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z_re  <= n_z_re;
        r_z_im  <= n_z_im;
        r_count <= n_count;
    end

    assign o_ctrl  = r_ctrl;
    assign o_z_re  = r_z_re;
    assign o_z_im  = r_z_im;
    assign o_count = r_count;

    `MBE_ASSERT_IMPL(a_done_needs_valid, r_ctrl.done, r_ctrl.valid, "finished flag on an empty cell")

endmodule

FILE: hdl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// Escape-time iteration unit: maps a pixel to a complex point and iterates z = z*z + c.
// Depends on mbe_pkg, mbe_map, mbe_cell and assert_macros.svh.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_pixel_col and i_pixel_row.
//   Output channel: o_out_valid / i_out_stall with o_iter_count and o_inside_set.
//   A transfer takes place on a rising edge with valid high and stall low.
//   Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index
//   (0 spacing, 1 centre real, 2 centre imaginary, 3 origin offset, 4 limit);
//   write only while no pixel is in flight.
//   One pixel is worked on at a time. After the mapping cycle it circulates in a
//   ring of CELLS iteration cells, one escape test and one z update per cycle.
//   The result is presented once the pixel has stopped iterating and leaves the
//   last cell; the input stall drops as it appears, so the next pixel can be taken.
//   The output register holds a finished result while the receiver stalls;
//   the next pixel may already be accepted and worked on meanwhile, and a pixel
//   that finishes before the register frees keeps circling the ring.
//   Reset (synchronous) empties the ring and the output register and loads the
//   default configuration.
module mandelbrot_escape_time_unit #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 24,
    parameter int COUNT_BITS = 8,
    parameter int CELLS      = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [2:0]                          i_cfg_index,
    input  logic [mbe_pkg::WORD_BITS-1:0]       i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [COORD_BITS-1:0]               i_pixel_col,
    input  logic [COORD_BITS-1:0]               i_pixel_row,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [COUNT_BITS-1:0]               o_iter_count,
    output logic                                o_inside_set
);
    import mbe_pkg::*;

    localparam logic [2:0] CFG_PIXEL_SPACING   = 3'd0;
    localparam logic [2:0] CFG_CENTRE_REAL     = 3'd1;
    localparam logic [2:0] CFG_CENTRE_IMAG     = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_OFFSET   = 3'd3;
    localparam logic [2:0] CFG_ITERATION_LIMIT = 3'd4;

    localparam logic [SPACING_BITS-1:0]   RST_PIXEL_SPACING = SPACING_BITS'(41943);
    localparam logic signed [WORD_BITS-1:0] RST_CENTRE_REAL = WORD_BITS'(19461079);
    localparam logic signed [WORD_BITS-1:0] RST_CENTRE_IMAG = WORD_BITS'(2684355);
    localparam logic [COORD_BITS-1:0]     RST_ORIGIN_OFFSET = COORD_BITS'(400);
    localparam logic [COUNT_BITS-1:0]     RST_ITER_LIMIT    = COUNT_BITS'(50);

    logic [SPACING_BITS-1:0]     r_pixel_spacing;
    logic signed [WORD_BITS-1:0] r_centre_real;
    logic signed [WORD_BITS-1:0] r_centre_imag;
    logic [COORD_BITS-1:0]       r_origin_offset;
    logic [COUNT_BITS-1:0]       r_iteration_limit;

    logic                        r_busy;
    logic                        r_inject;
    logic                        r_out_valid;
    logic [COUNT_BITS-1:0]       r_out_count;
    logic                        r_out_inside;

    logic                        w_in_xfer;
    logic                        w_out_free;
    logic                        w_exit;
    logic signed [WORD_BITS-1:0] w_point_re;
    logic signed [WORD_BITS-1:0] w_point_im;

    t_cell_ctrl                  w_head_ctrl;
    logic signed [WORD_BITS-1:0] w_head_z_re;
    logic signed [WORD_BITS-1:0] w_head_z_im;
    logic [COUNT_BITS-1:0]       w_head_count;

    t_cell_ctrl                  w_in_ctrl    [CELLS];
    logic signed [WORD_BITS-1:0] w_in_z_re    [CELLS];
    logic signed [WORD_BITS-1:0] w_in_z_im    [CELLS];
    logic [COUNT_BITS-1:0]       w_in_count   [CELLS];
    t_cell_ctrl                  w_out_ctrl   [CELLS];
    logic signed [WORD_BITS-1:0] w_out_z_re   [CELLS];
    logic signed [WORD_BITS-1:0] w_out_z_im   [CELLS];
    logic [COUNT_BITS-1:0]       w_out_count  [CELLS];
    logic [CELLS-1:0]            w_ring_valid;
    t_cell_ctrl                  w_last_ctrl;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_spacing   <= RST_PIXEL_SPACING;
            r_centre_real     <= RST_CENTRE_REAL;
            r_centre_imag     <= RST_CENTRE_IMAG;
            r_origin_offset   <= RST_ORIGIN_OFFSET;
            r_iteration_limit <= RST_ITER_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PIXEL_SPACING:   r_pixel_spacing   <= i_cfg_wdata[SPACING_BITS-1:0];
                CFG_CENTRE_REAL:     r_centre_real     <= i_cfg_wdata;
                CFG_CENTRE_IMAG:     r_centre_imag     <= i_cfg_wdata;
                CFG_ORIGIN_OFFSET:   r_origin_offset   <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_wdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = r_busy;
    assign w_in_xfer  = i_in_valid && !r_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_ctrl = w_out_ctrl[CELLS-1];
    assign w_exit     = w_last_ctrl.valid && w_last_ctrl.done && w_out_free;

    mbe_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .i_clk           (i_clk),
        .i_load          (w_in_xfer),
        .i_pixel_col     (i_pixel_col),
        .i_pixel_row     (i_pixel_row),
        .i_origin_offset (r_origin_offset),
        .i_pixel_spacing (r_pixel_spacing),
        .i_centre_real   (r_centre_real),
        .i_centre_imag   (r_centre_imag),
        .o_point_re      (w_point_re),
        .o_point_im      (w_point_im)
    );

    // head of the ring: fresh pixel, recirculate, or drop on exit
    always_comb begin
        w_head_ctrl  = '0;
        w_head_z_re  = w_out_z_re[CELLS-1];
        w_head_z_im  = w_out_z_im[CELLS-1];
        w_head_count = w_out_count[CELLS-1];
        if (r_inject) begin
            w_head_ctrl.valid = 1'b1;
            w_head_ctrl.done  = 1'b0;
            w_head_z_re       = '0;
            w_head_z_im       = '0;
            w_head_count      = '0;
        end else if (w_last_ctrl.valid && !w_exit) begin
            w_head_ctrl = w_last_ctrl;
        end
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_in_ctrl[k]  = w_head_ctrl;
            assign w_in_z_re[k]  = w_head_z_re;
            assign w_in_z_im[k]  = w_head_z_im;
            assign w_in_count[k] = w_head_count;
        end else begin : g_link
            assign w_in_ctrl[k]  = w_out_ctrl[k-1];
            assign w_in_z_re[k]  = w_out_z_re[k-1];
            assign w_in_z_im[k]  = w_out_z_im[k-1];
            assign w_in_count[k] = w_out_count[k-1];
        end

        mbe_cell #(
            .FRAC_BITS  (FRAC_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_in_ctrl[k]),
            .i_z_re     (w_in_z_re[k]),
            .i_z_im     (w_in_z_im[k]),
            .i_count    (w_in_count[k]),
            .i_point_re (w_point_re),
            .i_point_im (w_point_im),
            .i_limit    (r_iteration_limit),
            .o_ctrl     (w_out_ctrl[k]),
            .o_z_re     (w_out_z_re[k]),
            .o_z_im     (w_out_z_im[k]),
            .o_count    (w_out_count[k])
        );

        assign w_ring_valid[k] = w_out_ctrl[k].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject <= w_in_xfer;
            if (w_in_xfer) begin
                r_busy <= 1'b1;
            end else if (w_exit) begin
                r_busy <= 1'b0;
            end
            if (w_exit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit) begin
            r_out_count  <= w_out_count[CELLS-1];
            r_out_inside <= w_out_count[CELLS-1] >= r_iteration_limit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_iter_count = r_out_count;
    assign o_inside_set = r_out_inside;

    `MBE_ASSERT(a_ring_single, $countones(w_ring_valid) <= 1, "more than one pixel in the ring")
    `MBE_ASSERT_IMPL(a_idle_empty, !r_busy, (w_ring_valid == '0) && !r_inject, "idle unit holds a pixel")
    `MBE_ASSERT_IMPL(a_exit_count, w_exit, w_out_count[CELLS-1] <= r_iteration_limit, "count beyond limit")
    `MBE_ASSERT_NEXT(a_exit_result, w_exit, o_out_valid && !r_busy, "finished pixel not presented")

endmodule
